### hdl/cma_pkg.sv
// Package of shared types, constants and the sequencer state type of the moving-average unit.
`timescale 1ns / 1ps

package cma_pkg;

  localparam int unsigned SAMPLE_W            = 8;
  localparam int unsigned CFG_W               = 4;
  localparam int unsigned MAX_HALF_WINDOW_DEF = 8;
  localparam logic [CFG_W-1:0] HALF_WINDOW_RST = 4'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                end_of_stream;
  } cma_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic                last_out;
  } cma_out_t;

  typedef logic [CFG_W-1:0] cma_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_DIVGO,
    ST_DIV,
    ST_EMIT,
    ST_NEXT
  } cma_state_e;

endpackage

### hdl/cma_stream_if.sv
// Valid/ready channel interface carrying one payload beat of a chosen type.
`timescale 1ns / 1ps

interface cma_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/cma_window.sv
// Sample shift store holding the newest sample at entry 0, with one indexed read port.
`timescale 1ns / 1ps

module cma_window #(
  parameter int unsigned DEPTH = 2 * cma_pkg::MAX_HALF_WINDOW_DEF + 1,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          shift_i,
  input  logic [cma_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic [IDX_W-1:0]              rd_idx_i,
  output logic [cma_pkg::SAMPLE_W-1:0]  rd_data_o
);
  import cma_pkg::*;

  logic [SAMPLE_W-1:0] store_q [DEPTH];

  // Entries are only read once this stream has written them, so no reset.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      store_q[0] <= sample_i;
      for (int unsigned i = 1; i < DEPTH; i++) begin
        store_q[i] <= store_q[i-1];
      end
    end
  end

  assign rd_data_o = store_q[rd_idx_i];

endmodule

### hdl/cma_divider.sv
// Restoring serial divider producing one quotient bit per cycle.
`timescale 1ns / 1ps

module cma_divider #(
  parameter int unsigned DIVIDEND_W = 13,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);
  import cma_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  div_q, div_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    trial;
  logic                  ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DIVIDEND_W);
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q - 1'b1;
        rem_d  = ge ? DIVISOR_W'(trial - {1'b0, div_q}) : trial[DIVISOR_W-1:0];
        quo_d  = {quo_q[DIVIDEND_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o     = busy_q && (step_q == '0);
  assign quotient_o = quo_q;

endmodule

### hdl/centered_moving_average_unit.sv
// Top level of the centred moving-average unit: sequencer, window store and serial divider.
// Each result sums the hi + 1 samples of its window in turn, then divides the sum by that
// count in the serial divider (DIVIDEND_W = 13 at the default size, one quotient bit a cycle);
// a skipped position only passes the check and next states. A non-final beat yields at most
// one result; a final beat flushes up to half_window + 1 results. Input is taken only when the
// sequencer is idle. Reset clears control state at once; there is no clearing pass.
`timescale 1ns / 1ps

module centered_moving_average_unit #(
  parameter int unsigned MAX_HALF_WINDOW = cma_pkg::MAX_HALF_WINDOW_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cma_stream_if.sink   in_i,
  cma_stream_if.source out_o,
  cma_stream_if.sink   cfg_i
);
  import cma_pkg::*;

  // The store holds the centre sample plus MAX_HALF_WINDOW samples on each side.
  localparam int unsigned DEPTH  = 2 * MAX_HALF_WINDOW + 1;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  // Counts, positions and half widths all fit below or at DEPTH.
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  // A full window of maximum samples sets the width of the sum.
  localparam int unsigned SUM_W  = $clog2(255 * DEPTH + 1);
  // Width used to clamp the 4-bit register against the maximum half window.
  localparam int unsigned HC_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // ---------------------------------------------------------------------------------------
  // Configuration register. The user must write it only while idle; the block does not enforce
  // this. Each beat latches the effective half window, so the register needs no shadow copy.
  // ---------------------------------------------------------------------------------------
  cma_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= HALF_WINDOW_RST;
    end else if (cfg_i.valid) begin
      cfg_q <= cfg_i.data;
    end
  end

  // A value above the maximum acts as the maximum.
  logic [HC_W-1:0] cfg_ext;
  logic [HC_W-1:0] h_clamped;

  assign cfg_ext   = HC_W'(cfg_q);
  assign h_clamped = (cfg_ext > HC_W'(MAX_HALF_WINDOW)) ? HC_W'(MAX_HALF_WINDOW) : cfg_ext;

  // ---------------------------------------------------------------------------------------
  // Sequencer state and datapath registers.
  // ---------------------------------------------------------------------------------------
  cma_state_e state_q, state_d;

  logic [CNT_W-1:0] fill_q;   // samples received in this stream, saturating at DEPTH
  logic [CNT_W-1:0] h_q;      // effective half window of the current beat
  logic [CNT_W-1:0] d_q;      // store entry of the centre sample being worked on
  logic [CNT_W-1:0] hi_q;     // newest-to-oldest extent of the cut window
  logic [CNT_W-1:0] k_q;      // summation pointer
  logic [SUM_W-1:0] acc_q;    // running window sum
  logic             last_q;   // current beat closes the stream

  cma_out_t out_data_q;
  logic     out_valid_q;

  // Control strobes from the output decoder.
  logic in_ready;
  logic in_beat;
  logic do_check;
  logic do_sum;
  logic div_start;
  logic load_out;
  logic step_next;

  logic emit_ok;
  logic pos_valid;
  logic sum_done;
  logic div_done;
  logic final_pos;

  assign in_beat   = in_i.valid && in_ready;
  // The output register may be refilled in the same cycle that its beat is taken.
  assign emit_ok   = !out_valid_q || out_o.ready;
  // A position is present once the stream has reached d entries back.
  assign pos_valid = (fill_q > d_q);
  assign sum_done  = (k_q == hi_q);
  // Only the final beat of a stream walks down to the newest sample.
  assign final_pos = !last_q || (d_q == '0);

  // Window extent: right side is d samples, left side is cut at the stream start.
  logic [CNT_W-1:0] pos_c;
  logic [CNT_W-1:0] left_w;

  assign pos_c  = fill_q - 1'b1 - d_q;
  assign left_w = (pos_c < h_q) ? pos_c : h_q;

  // ---------------------------------------------------------------------------------------
  // Next-state logic.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = pos_valid ? ST_SUM : ST_NEXT;
      end
      ST_SUM: begin
        if (sum_done) begin
          state_d = ST_DIVGO;
        end
      end
      ST_DIVGO: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        state_d = final_pos ? ST_IDLE : ST_CHECK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Output decoder.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    do_check  = 1'b0;
    do_sum    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    step_next = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready  = 1'b1;
      ST_CHECK: do_check  = 1'b1;
      ST_SUM:   do_sum    = 1'b1;
      ST_DIVGO: div_start = 1'b1;
      ST_DIV:   ;
      ST_EMIT:  load_out  = emit_ok;
      ST_NEXT:  step_next = 1'b1;
      default:  ;
    endcase
  end

  assign in_i.ready = in_ready;

  // ---------------------------------------------------------------------------------------
  // Window store and divider.
  // ---------------------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] rd_data;
  logic [SUM_W-1:0]    quotient;

  cma_window #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_window (
    .clk_i     (clk_i),
    .shift_i   (in_beat),
    .sample_i  (in_i.data.sample),
    .rd_idx_i  (IDX_W'(k_q)),
    .rd_data_o (rd_data)
  );

  cma_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (hi_q + 1'b1),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // ---------------------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_beat && (fill_q < CNT_W'(DEPTH))) begin
        fill_q <= fill_q + 1'b1;
      end else if (step_next && final_pos && last_q) begin
        // The stream is closed; the next beat starts a fresh one.
        fill_q <= '0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      h_q    <= CNT_W'(h_clamped);
      d_q    <= CNT_W'(h_clamped);
      last_q <= in_i.data.end_of_stream;
    end
    if (do_check) begin
      hi_q  <= d_q + left_w;
      k_q   <= '0;
      acc_q <= '0;
    end
    if (do_sum) begin
      acc_q <= acc_q + SUM_W'(rd_data);
      k_q   <= k_q + 1'b1;
    end
    if (step_next && !final_pos) begin
      d_q <= d_q - 1'b1;
    end
    if (load_out) begin
      // The mean of bytes never exceeds a byte, so the low bits are the whole quotient.
      out_data_q.mean     <= quotient[SAMPLE_W-1:0];
      out_data_q.last_out <= last_q && (d_q == '0);
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

### hdl/cma_checker.sv
// Port-level assertions for the moving-average unit, and the bind that attaches them.
`timescale 1ns / 1ps

module cma_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input cma_pkg::cma_out_t out_data_i
);
  import cma_pkg::*;

  logic in_beat;

  assign in_beat = in_valid_i && in_ready_i;

  // The sequencer is busy in the cycle after it takes a beat.
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_ready_i)
    else $error("input ready straight after an accepted beat");

  // A result needs summing and dividing, so none appears right after a beat.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !$rose(out_valid_i))
    else $error("result appeared one cycle after an input beat");

  // A fresh result is produced only while the sequencer is working.
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !in_ready_i)
    else $error("result appeared while input was ready");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or dropped");

endmodule

bind centered_moving_average_unit cma_checker u_cma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
